FILE: design/hrct_pkg.sv
// Package for the heart rate confidence tracker: widths, constants, codes and control types.
package hrct_pkg;

	// Field widths
	localparam int IR_W    = 18;
	localparam int TIME_W  = 32;
	localparam int BPM_W   = 16;
	localparam int CONF_W  = 7;
	localparam int TX_W    = 16;
	localparam int ID_W    = 8;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;

	// Serial divider geometry
	localparam int NUM_W     = 34;
	localparam int DEN_W     = 32;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	// 60e6 * 256: Q8.8 beats per minute from a microsecond interval
	localparam logic [NUM_W-1:0] RATE_NUM = 34'd15360000000;

	// Decay by 0.98 as floor(rate * 49 / 50); the divide by 50 is a multiply by
	// ceil(2^28 / 50) and a shift, exact for every product below 2^22
	localparam int PROD_W   = BPM_W + 6;
	localparam int RECIP_W  = 23;
	localparam int DECAY_SH = 28;
	localparam logic [PROD_W-1:0]  DECAY_MUL   = PROD_W'(49);
	localparam logic [RECIP_W-1:0] DECAY_RECIP = RECIP_W'(5368710);

	// Confidence codes
	localparam logic [CONF_W-1:0] CONF_NONE    = 7'd0;
	localparam logic [CONF_W-1:0] CONF_STALE   = 7'd20;
	localparam logic [CONF_W-1:0] CONF_WARM    = 7'd30;
	localparam logic [CONF_W-1:0] CONF_PEER    = 7'd50;
	localparam logic [CONF_W-1:0] CONF_HEALTHY = 7'd100;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_CONTACT_THR = 3'd0;
	localparam logic [IDX_W-1:0] REG_COLD_START  = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_INTV    = 3'd2;
	localparam logic [IDX_W-1:0] REG_STALE       = 3'd3;
	localparam logic [IDX_W-1:0] REG_TX_INTV     = 3'd4;
	localparam logic [IDX_W-1:0] REG_PEER_MIN    = 3'd5;
	localparam logic [IDX_W-1:0] REG_INIT_GOOD   = 3'd6;
	localparam logic [IDX_W-1:0] REG_NODE_ID     = 3'd7;

	// Register reset values
	localparam logic [IR_W-1:0]   RST_CONTACT_THR = 18'd30000;
	localparam logic [TIME_W-1:0] RST_COLD_START  = 32'd3000000;
	localparam logic [TIME_W-1:0] RST_MIN_INTV    = 32'd250000;
	localparam logic [TIME_W-1:0] RST_STALE       = 32'd5000000;
	localparam logic [TX_W-1:0]   RST_TX_INTV     = 16'd100;
	localparam logic [CONF_W-1:0] RST_PEER_MIN    = 7'd60;
	localparam logic [BPM_W-1:0]  RST_INIT_GOOD   = 16'd18432;
	localparam logic [ID_W-1:0]   RST_NODE_ID     = 8'd1;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic in_ready;
		logic eval;
		logic div_start;
		logic decay;
		logic div_apply;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_take;
		logic contact;
		logic beat;
		logic cold;
		logic measure;
		logic stale;
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: design/hrct_in_if.sv
// Input channel: one sensor poll per item.
interface hrct_in_if;
	import hrct_pkg::*;

	logic              valid;
	logic              ready;
	logic [IR_W-1:0]   ir_sample;
	logic              beat_seen;
	logic [TIME_W-1:0] now_us;
	logic [TIME_W-1:0] now_ms;
	logic              peer_contact;
	logic [CONF_W-1:0] peer_confidence;
	logic [BPM_W-1:0]  peer_bpm;

	modport source (
		output valid, ir_sample, beat_seen, now_us, now_ms,
		       peer_contact, peer_confidence, peer_bpm,
		input  ready
	);

	modport sink (
		input  valid, ir_sample, beat_seen, now_us, now_ms,
		       peer_contact, peer_confidence, peer_bpm,
		output ready
	);

endinterface

FILE: design/hrct_out_if.sv
// Output channel: one report per item.
interface hrct_out_if;
	import hrct_pkg::*;

	logic              valid;
	logic              ready;
	logic              send_now;
	logic [ID_W-1:0]   report_id;
	logic [BPM_W-1:0]  rate_bpm;
	logic [CONF_W-1:0] confidence_pct;
	logic              has_contact;
	logic [TIME_W-1:0] since_beat_us;

	modport source (
		output valid, send_now, report_id, rate_bpm, confidence_pct,
		       has_contact, since_beat_us,
		input  ready
	);

	modport sink (
		input  valid, send_now, report_id, rate_bpm, confidence_pct,
		       has_contact, since_beat_us,
		output ready
	);

endinterface

FILE: design/hrct_div.sv
// Restoring serial divider, one quotient bit per cycle.
module hrct_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hrct_pkg::NUM_W-1:0] num,
	input  logic [hrct_pkg::DEN_W-1:0] den,
	output logic                       done,
	output logic [hrct_pkg::NUM_W-1:0] quo
);
	import hrct_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] trial;
	logic             fits;

	// Trial subtract of the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		fits    = ~trial[DEN_W+1];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			dvs_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: design/hrct_ctrl.sv
// Controller state machine: sequences evaluation, division and result hand-off.
module hrct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  hrct_pkg::dp_sts_t  sts,
	output hrct_pkg::dp_cmd_t  cmd
);
	import hrct_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   need_rate;
	logic   need_decay;

	// Which polls measure a rate and which decay a stale one
	always_comb begin
		need_rate  = sts.contact & sts.beat & ~sts.cold & sts.measure;
		need_decay = sts.contact & ~sts.beat & sts.stale;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sts.in_take) state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = need_rate ? S_DIV : S_DONE;
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			S_EVAL: begin
				cmd.eval      = 1'b1;
				cmd.div_start = need_rate;
				cmd.decay     = need_decay;
			end
			S_DIV: begin
				cmd.div_apply = sts.div_done;
			end
			S_DONE: begin
				cmd.load_out = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

FILE: design/hrct_dp.sv
// Datapath: configuration, tracker state, decisions, divider and output register.
module hrct_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hrct_pkg::IDX_W-1:0] cfg_index,
	input  logic [hrct_pkg::CFG_W-1:0] cfg_data,
	hrct_in_if.sink                    in_ch,
	hrct_out_if.source                 out_ch,
	input  hrct_pkg::dp_cmd_t          cmd,
	output hrct_pkg::dp_sts_t          sts
);
	import hrct_pkg::*;

	// Configuration registers
	logic [IR_W-1:0]   thr_q;
	logic [TIME_W-1:0] cold_q;
	logic [TIME_W-1:0] min_q;
	logic [TIME_W-1:0] stale_q;
	logic [TX_W-1:0]   tx_q;
	logic [CONF_W-1:0] pmin_q;
	logic [BPM_W-1:0]  init_good_q;
	logic [ID_W-1:0]   node_q;

	// Tracker state
	logic [TIME_W-1:0] last_beat_q;
	logic [TIME_W-1:0] last_send_q;
	logic [BPM_W-1:0]  last_good_q;
	logic [BPM_W-1:0]  rate_q;
	logic [CONF_W-1:0] conf_q;
	logic              beat_valid_q;
	logic              send_q;

	// Latched poll
	logic [IR_W-1:0]   ir_q;
	logic              beat_q;
	logic [TIME_W-1:0] now_us_q;
	logic [TIME_W-1:0] now_ms_q;
	logic              pcon_q;
	logic [CONF_W-1:0] pconf_q;
	logic [BPM_W-1:0]  pbpm_q;

	// Output register
	logic              out_valid_q;
	logic              o_send_q;
	logic [ID_W-1:0]   o_id_q;
	logic [BPM_W-1:0]  o_rate_q;
	logic [CONF_W-1:0] o_conf_q;
	logic              o_contact_q;
	logic [TIME_W-1:0] o_since_q;

	logic                      in_take;
	logic                      contact;
	logic                      borrow;
	logic [TIME_W-1:0]         delta;
	logic [TIME_W-1:0]         ms_delta;
	logic [PROD_W-1:0]         decay_prod;
	logic [PROD_W+RECIP_W-1:0] decay_wide;
	logic [BPM_W-1:0]          decay_rate;
	logic                      div_done;
	logic [NUM_W-1:0]          div_quo;
	logic [BPM_W-1:0]          meas_rate;

	// Decisions on the latched poll
	always_comb begin
		in_take    = in_ch.valid & cmd.in_ready;
		contact    = ir_q > thr_q;
		borrow     = pcon_q & (pconf_q > pmin_q);
		delta      = now_us_q - last_beat_q;
		ms_delta   = now_ms_q - last_send_q;
		// rate * 49 / 50 through the reciprocal of 50
		decay_prod = PROD_W'(rate_q) * DECAY_MUL;
		decay_wide = (PROD_W+RECIP_W)'(decay_prod) * (PROD_W+RECIP_W)'(DECAY_RECIP);
		decay_rate = decay_wide[DECAY_SH +: BPM_W];
		meas_rate  = (|div_quo[NUM_W-1:BPM_W]) ? {BPM_W{1'b1}} : div_quo[BPM_W-1:0];
	end

	assign in_ch.ready = cmd.in_ready;

	always_comb begin
		sts.in_take  = in_take;
		sts.contact  = contact;
		sts.beat     = beat_q;
		sts.cold     = delta > cold_q;
		sts.measure  = delta > min_q;
		sts.stale    = delta > stale_q;
		sts.div_done = div_done;
		sts.out_free = ~out_valid_q | out_ch.ready;
	end

	// Poll capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			ir_q     <= in_ch.ir_sample;
			beat_q   <= in_ch.beat_seen;
			now_us_q <= in_ch.now_us;
			now_ms_q <= in_ch.now_ms;
			pcon_q   <= in_ch.peer_contact;
			pconf_q  <= in_ch.peer_confidence;
			pbpm_q   <= in_ch.peer_bpm;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= RST_CONTACT_THR;
			cold_q      <= RST_COLD_START;
			min_q       <= RST_MIN_INTV;
			stale_q     <= RST_STALE;
			tx_q        <= RST_TX_INTV;
			pmin_q      <= RST_PEER_MIN;
			init_good_q <= RST_INIT_GOOD;
			node_q      <= RST_NODE_ID;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONTACT_THR: thr_q       <= cfg_data[IR_W-1:0];
				REG_COLD_START:  cold_q      <= cfg_data[TIME_W-1:0];
				REG_MIN_INTV:    min_q       <= cfg_data[TIME_W-1:0];
				REG_STALE:       stale_q     <= cfg_data[TIME_W-1:0];
				REG_TX_INTV:     tx_q        <= cfg_data[TX_W-1:0];
				REG_PEER_MIN:    pmin_q      <= cfg_data[CONF_W-1:0];
				REG_INIT_GOOD:   init_good_q <= cfg_data[BPM_W-1:0];
				REG_NODE_ID:     node_q      <= cfg_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// Tracker state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_beat_q  <= '0;
			last_send_q  <= '0;
			last_good_q  <= RST_INIT_GOOD;
			rate_q       <= '0;
			conf_q       <= CONF_NONE;
			beat_valid_q <= 1'b0;
			send_q       <= 1'b0;
		end else begin
			// Writing the initial good rate also reloads the last good rate
			if (cfg_we && cfg_index == REG_INIT_GOOD) begin
				last_good_q <= cfg_data[BPM_W-1:0];
			end
			if (cmd.eval) begin
				if (contact) begin
					if (beat_q) begin
						last_beat_q  <= now_us_q;
						beat_valid_q <= 1'b1;
						if (delta > cold_q) begin
							conf_q <= CONF_WARM;
							rate_q <= last_good_q;
						end
					end else if (cmd.decay) begin
						// no beat for too long: decay the rate
						rate_q <= decay_rate;
						conf_q <= CONF_STALE;
					end
				end else if (borrow) begin
					rate_q <= pbpm_q;
					conf_q <= CONF_PEER;
				end else begin
					rate_q <= '0;
					conf_q <= CONF_NONE;
				end
				send_q <= ms_delta > TIME_W'(tx_q);
				if (ms_delta > TIME_W'(tx_q)) begin
					last_send_q <= now_ms_q;
				end
			end
			// Divider result: measured rate
			if (cmd.div_apply) begin
				rate_q      <= meas_rate;
				last_good_q <= meas_rate;
				conf_q      <= CONF_HEALTHY;
			end
		end
	end

	// Serial divider for the measured rate
	hrct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (RATE_NUM),
		.den    (delta),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			o_send_q    <= send_q;
			o_id_q      <= node_q;
			o_rate_q    <= rate_q;
			o_conf_q    <= conf_q;
			o_contact_q <= contact;
			o_since_q   <= beat_valid_q ? (now_us_q - last_beat_q) : '0;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.send_now       = o_send_q;
	assign out_ch.report_id      = o_id_q;
	assign out_ch.rate_bpm       = o_rate_q;
	assign out_ch.confidence_pct = o_conf_q;
	assign out_ch.has_contact    = o_contact_q;
	assign out_ch.since_beat_us  = o_since_q;

endmodule

FILE: design/heart_rate_confidence_tracker.sv
// Top level of the heart rate confidence tracker: controller plus datapath.
//
// Each poll item produces exactly one report item. A poll that does not measure a
// beat interval passes from acceptance through the evaluation and done states to
// its registered report; a stale rate is decayed in the evaluation cycle by a
// reciprocal multiply. A poll that measures a rate (beat with an interval between
// the minimum and cold-start limits) also waits in the divide state while the
// 34-step serial divider works out 15360000000/interval. A full output register
// keeps the block in the done state until its report is taken. One poll is worked
// at a time; the next can be accepted in the cycle after the previous report
// is loaded into the output register, even while that report still waits to be
// taken. Configuration writes go through cfg_we/cfg_index/cfg_data while the
// block is idle; the user must keep to this, as the block does not enforce it.
// Writing initial_good_bpm also reloads the last good rate.
module heart_rate_confidence_tracker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hrct_pkg::IDX_W-1:0] cfg_index,
	input  logic [hrct_pkg::CFG_W-1:0] cfg_data,
	hrct_in_if.sink                    in_ch,
	hrct_out_if.source                 out_ch
);
	import hrct_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	hrct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath
	hrct_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: verif/hrct_checker.sv
// Scoreboard for the heart rate tracker: mirrors the registers, predicts each report, compares.
`timescale 1ns / 100ps

module hrct_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hrct_pkg::IDX_W-1:0] cfg_index,
	input  logic [hrct_pkg::CFG_W-1:0] cfg_data,
	hrct_in_if                         in_ch,
	hrct_out_if                        out_ch,
	output int                         fail_count,
	output int                         outstanding
);
	import hrct_pkg::*;

	// 60e6 us per minute, scaled by 256 for Q8.8
	localparam logic [63:0] RATE_SCALE = 64'd15360000000;

	typedef struct packed {
		logic              send_now;
		logic [ID_W-1:0]   report_id;
		logic [BPM_W-1:0]  rate_bpm;
		logic [CONF_W-1:0] confidence_pct;
		logic              has_contact;
		logic [TIME_W-1:0] since_beat_us;
	} report_t;

	// Register copies
	logic [IR_W-1:0]   thr;
	logic [TIME_W-1:0] cold_us, min_us, stale_lim;
	logic [TX_W-1:0]   tx_ms;
	logic [CONF_W-1:0] peer_min;
	logic [ID_W-1:0]   node;

	// Tracker state
	logic [TIME_W-1:0] beat_at, sent_at;
	logic [BPM_W-1:0]  good_rate, rate;
	logic [CONF_W-1:0] conf;
	logic              had_beat;

	report_t pending_reports[$];
	int      mism;

	// One poll in, one report out; updates the tracker state
	function automatic report_t poll_to_report(
		input logic [IR_W-1:0]   ir,
		input logic              beat,
		input logic [TIME_W-1:0] now_us,
		input logic [TIME_W-1:0] now_ms,
		input logic              p_contact,
		input logic [CONF_W-1:0] p_conf,
		input logic [BPM_W-1:0]  p_bpm
	);
		report_t     r;
		logic        contact;
		logic [31:0] gap;
		logic [31:0] scaled;
		logic [63:0] quot;
		contact = ir > thr;
		if (contact) begin
			if (beat) begin
				gap = now_us - beat_at;
				beat_at = now_us;
				had_beat = 1'b1;
				// cold-start test wins even when thresholds are swapped
				if (gap > cold_us) begin
					conf = CONF_WARM;
					rate = good_rate;
				end else if (gap > min_us) begin
					quot = RATE_SCALE / {32'd0, gap};
					rate = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
					good_rate = rate;
					conf = CONF_HEALTHY;
				end
			end
			// no beat for too long: stale, rate times 0.98 floored
			if (32'(now_us - beat_at) > stale_lim) begin
				conf = CONF_STALE;
				scaled = 32'(rate) * 32'd49 / 32'd50;
				rate = scaled[15:0];
			end
		end else if (p_contact && p_conf > peer_min) begin
			rate = p_bpm;
			conf = CONF_PEER;
		end else begin
			rate = '0;
			conf = CONF_NONE;
		end
		r.send_now = 1'b0;
		if (32'(now_ms - sent_at) > 32'(tx_ms)) begin
			r.send_now = 1'b1;
			sent_at = now_ms;
		end
		r.report_id      = node;
		r.rate_bpm       = rate;
		r.confidence_pct = conf;
		r.has_contact    = contact;
		r.since_beat_us  = had_beat ? 32'(now_us - beat_at) : 32'd0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t got;
		report_t want;
		if (!arst_n) begin
			thr       = RST_CONTACT_THR;
			cold_us   = RST_COLD_START;
			min_us    = RST_MIN_INTV;
			stale_lim = RST_STALE;
			tx_ms     = RST_TX_INTV;
			peer_min  = RST_PEER_MIN;
			node      = RST_NODE_ID;
			good_rate = RST_INIT_GOOD;
			beat_at   = '0;
			sent_at   = '0;
			rate      = '0;
			conf      = CONF_NONE;
			had_beat  = 1'b0;
			mism      = 0;
			pending_reports.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_CONTACT_THR: thr = cfg_data[IR_W-1:0];
					REG_COLD_START:  cold_us = cfg_data;
					REG_MIN_INTV:    min_us = cfg_data;
					REG_STALE:       stale_lim = cfg_data;
					REG_TX_INTV:     tx_ms = cfg_data[TX_W-1:0];
					REG_PEER_MIN:    peer_min = cfg_data[CONF_W-1:0];
					REG_INIT_GOOD:   good_rate = cfg_data[BPM_W-1:0];
					REG_NODE_ID:     node = cfg_data[ID_W-1:0];
					default: ;
				endcase
			end

			// report taken: compare with the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.send_now, out_ch.report_id, out_ch.rate_bpm,
					out_ch.confidence_pct, out_ch.has_contact, out_ch.since_beat_us};
				if (pending_reports.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("%0t: report with no poll waiting: rate=%0d conf=%0d",
							$realtime, got.rate_bpm, got.confidence_pct);
				end else begin
					want = pending_reports.pop_front();
					if (got !== want) begin
						mism++;
						if (mism <= 10) begin
							$display("%0t: report mismatch, expected send=%0b id=%0d rate=%0d",
								$realtime, want.send_now, want.report_id, want.rate_bpm);
							$display("   conf=%0d contact=%0b since=%0d", want.confidence_pct,
								want.has_contact, want.since_beat_us);
							$display("   got send=%0b id=%0d rate=%0d conf=%0d contact=%0b since=%0d",
								got.send_now, got.report_id, got.rate_bpm, got.confidence_pct,
								got.has_contact, got.since_beat_us);
						end
					end
				end
			end

			// poll taken: predict its report
			if (in_ch.valid && in_ch.ready)
				pending_reports.push_back(poll_to_report(in_ch.ir_sample, in_ch.beat_seen,
					in_ch.now_us, in_ch.now_ms, in_ch.peer_contact, in_ch.peer_confidence,
					in_ch.peer_bpm));

			fail_count  <= mism;
			outstanding <= pending_reports.size();
		end
	end

endmodule

FILE: verif/tb.sv
// Testbench top for the heart rate tracker: clock, reset, register settings and poll traffic.
`timescale 1ns / 100ps

module tb;
	import hrct_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 45;
	localparam int SEG_ITEMS   = 85;
	localparam int PHASES      = 6;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	hrct_in_if  in_ch();
	hrct_out_if out_ch();

	int fail_count;
	int outstanding;
	int polls_sent   = 0;
	int reports_seen = 0;
	int quiet        = 0;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int hold_reqs    = 0;

	// register values as last written, used to aim the stimulus
	logic [IR_W-1:0]   thr       = RST_CONTACT_THR;
	logic [TIME_W-1:0] cold_us   = RST_COLD_START;
	logic [TIME_W-1:0] min_us    = RST_MIN_INTV;
	logic [TIME_W-1:0] stale_lim = RST_STALE;
	logic [TX_W-1:0]   tx_ms     = RST_TX_INTV;
	logic [CONF_W-1:0] peer_min  = RST_PEER_MIN;

	// sensor timeline as sent so far
	logic [TIME_W-1:0] cur_us  = '0;
	logic [TIME_W-1:0] cur_ms  = '0;
	logic [TIME_W-1:0] beat_us = '0;
	logic [TIME_W-1:0] send_ms = '0;

	heart_rate_confidence_tracker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	hrct_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	// uniform pick in [lo, hi], clipped to 32 bits
	function automatic logic [31:0] pick_between(input longint lo, input longint hi);
		logic [63:0] r;
		logic [63:0] span;
		if (hi > 64'h0000_0000_FFFF_FFFF)
			hi = 64'h0000_0000_FFFF_FFFF;
		if (lo > hi)
			return hi[31:0];
		r = {$urandom, $urandom};
		span = hi - lo + 1;
		return 32'(lo + (r % span));
	endfunction

	// offer one poll, with random idle cycles first, until it is taken
	task automatic send_poll(
		input logic [IR_W-1:0]   ir,
		input logic              beat,
		input logic [TIME_W-1:0] us,
		input logic [TIME_W-1:0] ms,
		input logic              pc,
		input logic [CONF_W-1:0] pconf,
		input logic [BPM_W-1:0]  pbpm
	);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.ir_sample       <= ir;
		in_ch.beat_seen       <= beat;
		in_ch.now_us          <= us;
		in_ch.now_ms          <= ms;
		in_ch.peer_contact    <= pc;
		in_ch.peer_confidence <= pconf;
		in_ch.peer_bpm        <= pbpm;
		do @(posedge clk); while (!in_ch.ready);
		cur_us = us;
		cur_ms = ms;
		if (ir > thr && beat)
			beat_us = us;
		if (32'(ms - send_ms) > 32'(tx_ms))
			send_ms = ms;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_CONTACT_THR: thr = val[IR_W-1:0];
			REG_COLD_START:  cold_us = val;
			REG_MIN_INTV:    min_us = val;
			REG_STALE:       stale_lim = val;
			REG_TX_INTV:     tx_ms = val[TX_W-1:0];
			REG_PEER_MIN:    peer_min = val[CONF_W-1:0];
			default: ;
		endcase
	endtask

	// stop offering, wait for every report, then let the block settle
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// report side: random stalls, plus a long hold-off on request
	initial begin
		int hold_seen;
		int left;
		hold_seen = 0;
		left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left > 0) begin
				left--;
				out_ch.ready <= 1'b0;
			end else if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				left = HOLD_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// traffic counts and watchdog on handshake silence
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet <= 0;
			if (in_ch.valid && in_ch.ready)
				polls_sent <= polls_sent + 1;
			if (out_ch.valid && out_ch.ready)
				reports_seen <= reports_seen + 1;
		end else if (quiet >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d reports still due",
				IDLE_LIMIT, outstanding);
			$display("[heart_rate_confidence_tracker] ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [CFG_W-1:0]  cfg_val [8];
		logic [IR_W-1:0]   g_ir;
		logic              g_beat;
		logic [TIME_W-1:0] g_us;
		logic [TIME_W-1:0] g_ms;
		logic              g_pc;
		logic [CONF_W-1:0] g_pconf;
		logic [BPM_W-1:0]  g_pbpm;
		int                k;

		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= '0;
		cfg_data              <= '0;
		in_ch.valid           <= 1'b0;
		in_ch.ir_sample       <= '0;
		in_ch.beat_seen       <= 1'b0;
		in_ch.now_us          <= '0;
		in_ch.now_ms          <= '0;
		in_ch.peer_contact    <= 1'b0;
		in_ch.peer_confidence <= '0;
		in_ch.peer_bpm        <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			// new register setting once the block has drained
			if (ph > 0) begin
				wait_idle();
				case (ph)
					1: begin // typical spread
						cfg_val[REG_CONTACT_THR] = pick_between(1000, 200000);
						cfg_val[REG_COLD_START]  = pick_between(1000000, 6000000);
						cfg_val[REG_MIN_INTV]    = pick_between(100000, 600000);
						cfg_val[REG_STALE]       = pick_between(2000000, 10000000);
						cfg_val[REG_TX_INTV]     = pick_between(0, 300);
						cfg_val[REG_PEER_MIN]    = $urandom_range(0, 100);
						cfg_val[REG_INIT_GOOD]   = $urandom_range(0, 65535);
						cfg_val[REG_NODE_ID]     = $urandom_range(0, 255);
					end
					2: begin // all registers at their floor
						foreach (cfg_val[j])
							cfg_val[j] = '0;
					end
					3: begin // all registers at their ceiling: contact is impossible
						cfg_val[REG_CONTACT_THR] = 32'h3FFFF;
						cfg_val[REG_COLD_START]  = 32'hFFFF_FFFF;
						cfg_val[REG_MIN_INTV]    = 32'hFFFF_FFFF;
						cfg_val[REG_STALE]       = 32'hFFFF_FFFF;
						cfg_val[REG_TX_INTV]     = 32'hFFFF;
						cfg_val[REG_PEER_MIN]    = 100;
						cfg_val[REG_INIT_GOOD]   = 32'hFFFF;
						cfg_val[REG_NODE_ID]     = 32'hFF;
					end
					4: begin // cold-start limit below the minimum interval
						cfg_val[REG_CONTACT_THR] = pick_between(0, 50000);
						cfg_val[REG_COLD_START]  = 500000;
						cfg_val[REG_MIN_INTV]    = 2000000;
						cfg_val[REG_STALE]       = 4000000;
						cfg_val[REG_TX_INTV]     = 1;
						cfg_val[REG_PEER_MIN]    = 99;
						cfg_val[REG_INIT_GOOD]   = $urandom_range(0, 65535);
						cfg_val[REG_NODE_ID]     = $urandom_range(0, 255);
					end
					default: begin // short intervals so the rate saturates
						cfg_val[REG_CONTACT_THR] = pick_between(0, 262142);
						cfg_val[REG_COLD_START]  = 400000;
						cfg_val[REG_MIN_INTV]    = 1;
						cfg_val[REG_STALE]       = 1000000;
						cfg_val[REG_TX_INTV]     = 50;
						cfg_val[REG_PEER_MIN]    = 100;
						cfg_val[REG_INIT_GOOD]   = 18432;
						cfg_val[REG_NODE_ID]     = $urandom_range(0, 255);
					end
				endcase
				for (k = 0; k < 8; k++)
					write_reg(IDX_W'(k), cfg_val[k]);
				cfg_we <= 1'b0;
				@(posedge clk);
			end

			for (int seg = 0; seg < 4; seg++) begin
				case (seg)
					0: begin idle_pct = 0;  stall_pct <= 0;  end
					1: begin idle_pct = 88; stall_pct <= 0;  end
					2: begin idle_pct = 0;  stall_pct <= 88; end
					default: begin idle_pct = 30; stall_pct <= 30; end
				endcase

				// directed polls on the reset setting
				if (ph == 0 && seg == 0) begin
					send_poll(0, 0, 0, 0, 0, 0, 0);                          // nothing at all
					send_poll(30000, 1, 10, 100, 1, 61, 16'hFFFF);           // IR at threshold, borrow
					send_poll(30000, 0, 20, 101, 1, 60, 1234);               // peer conf not above
					send_poll(0, 0, 30, 150, 1, 127, 8000);                  // peer conf above 100
					send_poll(30001, 0, 1000, 201, 0, 0, 0);                 // contact, no beat yet
					send_poll(30001, 1, 4000000, 260, 0, 0, 0);              // first beat is cold
					send_poll(100000, 1, 5000000, 300, 0, 0, 0);             // measured rate
					send_poll(100000, 1, 5250000, 302, 0, 0, 0);             // interval at minimum
					send_poll(100000, 1, 5500001, 350, 0, 0, 0);             // just above minimum
					send_poll(100000, 1, 8500001, 420, 0, 0, 0);             // interval at cold limit
					send_poll(100000, 1, 11500002, 500, 0, 0, 0);            // just past cold limit
					send_poll(100000, 0, 16500002, 520, 0, 0, 0);            // exactly stale, no decay
					send_poll(100000, 0, 16500003, 640, 0, 0, 0);            // stale, decay
					send_poll(100000, 0, 16600000, 700, 1, 90, 500);         // decay again
					send_poll(0, 1, 17000000, 710, 0, 0, 0);                 // beat without contact
					send_poll(18'h3FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 127, 16'hFFFF);
					send_poll(18'h3FFFF, 1, 499999, 5, 1, 127, 16'hFFFF);    // times wrap
				end

				for (int i = 0; i < SEG_ITEMS; i++) begin
					// long output hold while polls keep coming
					if (ph == 1 && seg == 0 && i == 20)
						hold_reqs <= hold_reqs + 1;

					k = $urandom_range(0, 99);
					if (k < 75)
						g_ir = IR_W'(pick_between(longint'(thr) + 1, 262143));
					else if (k < 80)
						g_ir = thr;
					else if (k < 90)
						g_ir = IR_W'(pick_between(0, thr));
					else
						g_ir = IR_W'($urandom);

					g_beat = ($urandom_range(0, 99) < 45);
					k = $urandom_range(0, 99);
					if (g_beat) begin
						// aim the interval since the last counted beat
						if (k < 55) begin
							if (min_us < cold_us)
								g_us = beat_us + pick_between(longint'(min_us) + 1, cold_us);
							else
								g_us = beat_us + pick_between(longint'(cold_us) + 1, min_us);
						end else if (k < 65) begin
							g_us = beat_us + pick_between(0, min_us);
						end else if (k < 75) begin
							g_us = beat_us + pick_between(longint'(cold_us) + 1,
								longint'(cold_us) + 4000000);
						end else if (k < 90) begin
							case ($urandom_range(0, 3))
								0: g_us = beat_us + min_us;
								1: g_us = beat_us + min_us + 1;
								2: g_us = beat_us + cold_us;
								default: g_us = beat_us + cold_us + 1;
							endcase
						end else begin
							g_us = $urandom;
						end
					end else begin
						if (k < 70)
							g_us = cur_us + $urandom_range(0, 400000);
						else if (k < 85)
							g_us = beat_us + stale_lim + $urandom_range(0, 1);
						else if (k < 95)
							g_us = beat_us + stale_lim + $urandom_range(0, 2000000);
						else
							g_us = $urandom;
					end

					k = $urandom_range(0, 99);
					if (k < 60)
						g_ms = cur_ms + $urandom_range(0, 60);
					else if (k < 75)
						g_ms = send_ms + tx_ms + $urandom_range(0, 1);
					else if (k < 95)
						g_ms = cur_ms + pick_between(0, 2 * longint'(tx_ms) + 2);
					else
						g_ms = $urandom;

					g_pc = 1'($urandom_range(0, 1));
					k = $urandom_range(0, 99);
					if (k < 15)
						g_pconf = peer_min + CONF_W'($urandom_range(0, 1));
					else if (k < 80)
						g_pconf = CONF_W'($urandom_range(0, 100));
					else
						g_pconf = CONF_W'($urandom_range(0, 127));
					g_pbpm = BPM_W'($urandom_range(0, 65535));

					send_poll(g_ir, g_beat, g_us, g_ms, g_pc, g_pconf, g_pbpm);
				end

				// pause the polls until every report is back
				if (seg == 1)
					wait_idle();
			end
		end

		wait_idle();
		$display("Sent %0d polls and checked %0d reports over %0d register settings,",
			polls_sent, reports_seen, PHASES);
		$display("with input gaps, output stalls and one long output hold; %0d mismatches.",
			fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("[heart_rate_confidence_tracker] OK");
		else
			$display("[heart_rate_confidence_tracker] ERROR");
		$finish;
	end

endmodule

FILE: files.f
design/hrct_pkg.sv
design/hrct_in_if.sv
design/hrct_out_if.sv
design/hrct_div.sv
design/hrct_ctrl.sv
design/hrct_dp.sv
design/heart_rate_confidence_tracker.sv
verif/hrct_checker.sv
verif/tb.sv
